>>> rtl/lics_pkg.sv
`default_nettype none

package lics_pkg;

  localparam int LOG_FRAC_BITS_DEF = 16;

  // Leading-zero count of a 32-bit word (0..31)
  localparam int LZ_W = 5;

  localparam int INV_SCALE_W = 24;
  localparam logic [INV_SCALE_W-1:0] INV_SCALE_RESET = 24'd65536;

  // ln(2) as unsigned Q0.32
  localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

  // u = 1/2 in Q0.32; also the rounding constant for a shift by 32
  localparam logic [31:0] HALF_Q32 = 32'h8000_0000;

  localparam logic [31:0] SAMPLE_MIN = 32'h8000_0000;
  localparam logic [31:0] SAMPLE_MAX = 32'h7FFF_FFFF;

  // Flags that ride along with each item through the pipeline
  typedef struct packed {
    logic zero;  // u equal zero, result is forced
    logic neg;   // u <= 1/2, sample is negative
  } ctl_t;

endpackage

`default_nettype wire

>>> rtl/lics_norm.sv
`default_nettype none

module lics_norm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        uniform_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        x_out,
  output logic [lics_pkg::LZ_W-1:0] lz_out,
  output lics_pkg::ctl_t     ctl_out
);
  import lics_pkg::*;

  localparam int NSTEP = 5;

  logic              v_r   [NSTEP+1];
  logic [31:0]       m_r   [NSTEP+1];
  ctl_t              ctl_r [NSTEP+1];
  logic [LZ_W-1:0]   lz_r  [1:NSTEP];
  logic              rdy   [NSTEP+2];

  ctl_t              ctl_nxt;
  logic [31:0]       m_nxt;

  assign rdy[NSTEP+1] = out_ready;
  assign in_ready     = rdy[0];

  // Fold u into m in [1, 2^31]; the zero case travels with m = 0
  always_comb begin
    ctl_nxt.zero = (uniform_in == '0);
    ctl_nxt.neg  = (uniform_in <= HALF_Q32);
    m_nxt        = ctl_nxt.neg ? uniform_in : (32'd0 - uniform_in);
  end

  assign rdy[0] = !v_r[0] || rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      m_r[0]   <= m_nxt;
      ctl_r[0] <= ctl_nxt;
    end
  end

  // Log shifter: one power-of-two step per stage, count accumulates by OR
  genvar k;
  for (k = 1; k <= NSTEP; k++) begin : g_step
    localparam int SH = 32 >> k;
    logic [LZ_W-1:0] lz_in;
    logic [31:0]     mk_nxt;
    logic [LZ_W-1:0] lzk_nxt;

    if (k == 1) begin : g_first
      assign lz_in = '0;
    end else begin : g_next
      assign lz_in = lz_r[k-1];
    end

    always_comb begin
      if (m_r[k-1][31 -: SH] == '0) begin
        mk_nxt  = m_r[k-1] << SH;
        lzk_nxt = lz_in | LZ_W'(SH);
      end else begin
        mk_nxt  = m_r[k-1];
        lzk_nxt = lz_in;
      end
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        m_r[k]   <= mk_nxt;
        lz_r[k]  <= lzk_nxt;
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  assign out_valid = v_r[NSTEP];
  assign x_out     = m_r[NSTEP];
  assign lz_out    = lz_r[NSTEP];
  assign ctl_out   = ctl_r[NSTEP];

  a_zero_is_neg: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && ctl_r[0].zero |-> ctl_r[0].neg)
    else $error("zero input not marked negative");

  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && !ctl_r[0].zero |-> (m_r[0] != '0) && (m_r[0] <= HALF_Q32))
    else $error("folded value out of range");

  a_normalized: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NSTEP] && !ctl_r[NSTEP].zero |-> m_r[NSTEP][31])
    else $error("mantissa not normalized");

endmodule

`default_nettype wire

>>> rtl/lics_log2.sv
`default_nettype none

module lics_log2 #(
  parameter int LOG_FRAC_BITS = lics_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [31:0]                            x_in,
  input  logic [lics_pkg::LZ_W-1:0]              lz_in,
  input  lics_pkg::ctl_t                         ctl_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [lics_pkg::LZ_W+LOG_FRAC_BITS-1:0] t_out,
  output lics_pkg::ctl_t                         ctl_out
);
  import lics_pkg::*;

  localparam int F   = LOG_FRAC_BITS;
  localparam int T_W = LZ_W + F;

  logic             v_r    [F];
  logic [31:0]      x_r    [F];
  logic [F-1:0]     frac_r [F];
  logic [LZ_W-1:0]  lz_r   [F];
  ctl_t             ctl_r  [F];
  logic             rdy    [F+1];

  logic             tv_r;
  logic [T_W-1:0]   t_r;
  ctl_t             tctl_r;

  assign in_ready = rdy[0];
  assign rdy[F]   = !tv_r || out_ready;

  // One squaring of the Q1.31 mantissa per stage, one fraction bit out
  genvar i;
  for (i = 0; i < F; i++) begin : g_sq
    logic            vin;
    logic [31:0]     xin;
    logic [F-1:0]    fin;
    logic [LZ_W-1:0] lzin;
    ctl_t            cin;
    logic [63:0]     sq;
    logic [31:0]     x_nxt;

    if (i == 0) begin : g_first
      assign vin  = in_valid;
      assign xin  = x_in;
      assign fin  = '0;
      assign lzin = lz_in;
      assign cin  = ctl_in;
    end else begin : g_next
      assign vin  = v_r[i-1];
      assign xin  = x_r[i-1];
      assign fin  = frac_r[i-1];
      assign lzin = lz_r[i-1];
      assign cin  = ctl_r[i-1];
    end

    assign sq    = 64'(xin) * 64'(xin);
    // Square >= 2.0: emit a one and halve
    assign x_nxt = sq[63] ? sq[63:32] : sq[62:31];

    assign rdy[i] = !v_r[i] || rdy[i+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        x_r[i]    <= x_nxt;
        frac_r[i] <= {fin[F-2:0], sq[63]};
        lz_r[i]   <= lzin;
        ctl_r[i]  <= cin;
      end
    end
  end

  // t = 31 - log2(m) = lz - frac, in QF
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= 1'b0;
    end else if (rdy[F]) begin
      tv_r <= v_r[F-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[F]) begin
      t_r    <= {lz_r[F-1], {F{1'b0}}} - T_W'(frac_r[F-1]);
      tctl_r <= ctl_r[F-1];
    end
  end

  assign out_valid = tv_r;
  assign t_out     = t_r;
  assign ctl_out   = tctl_r;

  for (i = 0; i < F; i++) begin : g_chk
    a_mant_range: assert property (@(posedge clk) disable iff (!rst_n)
      v_r[i] && !ctl_r[i].zero |-> x_r[i][31])
      else $error("mantissa left [1,2)");
  end

  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    tv_r && !tctl_r.zero |-> t_r <= {5'd31, {F{1'b0}}})
    else $error("log term out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    tv_r && !out_ready |=> tv_r && $stable(t_r) && $stable(tctl_r))
    else $error("stalled output changed");

endmodule

`default_nettype wire

>>> rtl/lics_scale.sv
`default_nettype none

module lics_scale #(
  parameter int LOG_FRAC_BITS = lics_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [lics_pkg::LZ_W+LOG_FRAC_BITS-1:0] t_in,
  input  lics_pkg::ctl_t                          ctl_in,
  input  logic [lics_pkg::INV_SCALE_W-1:0]        inv_scale,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [31:0]                      sample_out,
  output logic                                    saturated
);
  import lics_pkg::*;

  localparam int F     = LOG_FRAC_BITS;
  localparam int T_W   = LZ_W + F;
  localparam int P1_W  = T_W + 32;
  localparam int P2_W  = T_W + INV_SCALE_W;
  localparam int MAG_W = P2_W + 1 - F;

  logic             va_r, vb_r, vc_r, ov_r;
  logic             rdy_a, rdy_b, rdy_c, rdy_d;
  logic [P1_W-1:0]  p1_r;
  logic [T_W-1:0]   ln_r;
  logic [P2_W-1:0]  p2_r;
  ctl_t             ctl_a_r, ctl_b_r, ctl_c_r;
  logic [31:0]      sample_r;
  logic             sat_r;

  logic [P1_W-1:0]  ln_sum;
  logic [P2_W:0]    mag_sum;
  logic [MAG_W-1:0] mag;
  logic [32:0]      mag_ext;
  logic [31:0]      sample_nxt;
  logic             sat_nxt;

  assign rdy_d    = !ov_r || out_ready;
  assign rdy_c    = !vc_r || rdy_d;
  assign rdy_b    = !vb_r || rdy_c;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  // ln = t * ln2, rounded half up to QF
  assign ln_sum  = p1_r + P1_W'(HALF_Q32);
  // mag = ln * (1/lambda), rounded half up to Q16.16
  assign mag_sum = (P2_W+1)'(p2_r) + ((P2_W+1)'(1) << (F - 1));
  assign mag     = mag_sum[P2_W:F];
  assign mag_ext = 33'(mag);

  always_comb begin
    sat_nxt    = 1'b0;
    sample_nxt = '0;
    if (ctl_c_r.zero) begin
      sample_nxt = SAMPLE_MIN;
      sat_nxt    = 1'b1;
    end else if (ctl_c_r.neg) begin
      if (mag_ext > {1'b0, SAMPLE_MIN}) begin
        sample_nxt = SAMPLE_MIN;
        sat_nxt    = 1'b1;
      end else begin
        sample_nxt = 32'(33'd0 - mag_ext);
      end
    end else begin
      if (mag_ext > {1'b0, SAMPLE_MAX}) begin
        sample_nxt = SAMPLE_MAX;
        sat_nxt    = 1'b1;
      end else begin
        sample_nxt = mag_ext[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_d) ov_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      p1_r    <= P1_W'(t_in) * P1_W'(LN2_Q32);
      ctl_a_r <= ctl_in;
    end
    if (rdy_b) begin
      ln_r    <= ln_sum[P1_W-1:32];
      ctl_b_r <= ctl_a_r;
    end
    if (rdy_c) begin
      p2_r    <= P2_W'(ln_r) * P2_W'(inv_scale);
      ctl_c_r <= ctl_b_r;
    end
    if (rdy_d) begin
      sample_r <= sample_nxt;
      sat_r    <= sat_nxt;
    end
  end

  assign out_valid  = ov_r;
  assign sample_out = sample_r;
  assign saturated  = sat_r;

  a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && sat_r |-> (sample_r == SAMPLE_MIN) || (sample_r == SAMPLE_MAX))
    else $error("flagged result not at a rail");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r && ctl_c_r.zero && rdy_d |=> ov_r && sat_r && (sample_r == SAMPLE_MIN))
    else $error("zero input not forced to minimum");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !ov_r)
    else $error("output valid after reset");

endmodule

`default_nettype wire

>>> rtl/laplace_inverse_cdf_sampler_core.sv
// Throughput: one sample per cycle while out_ready is high; each stage holds one
//   item and moves on its own ready, so bubbles close up and the pipe keeps filling
//   while the output stalls.
// Stages: 6 for fold and normalize, LOG_FRAC_BITS squarings plus one subtract, 4 for
//   the two multiplies, the ln rounding and the final round and clip.
// Reset (synchronous, rst_n low): all valid bits clear, inv_scale returns to 1.0.
`default_nettype none

module laplace_inverse_cdf_sampler_core #(
  parameter int LOG_FRAC_BITS = lics_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lics_pkg::INV_SCALE_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [31:0]                       in_uniform_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                out_sample_out,
  output logic                              out_saturated
);
  import lics_pkg::*;

  localparam int T_W = LZ_W + LOG_FRAC_BITS;

  logic [INV_SCALE_W-1:0] inv_scale_r;

  logic                   n_valid, n_ready;
  logic [31:0]            n_x;
  logic [LZ_W-1:0]        n_lz;
  ctl_t                   n_ctl;

  logic                   l_valid, l_ready;
  logic [T_W-1:0]         l_t;
  ctl_t                   l_ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_scale_r <= INV_SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      inv_scale_r <= cfg_data;
    end
  end

  lics_norm u_norm (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .uniform_in (in_uniform_in),
    .out_valid  (n_valid),
    .out_ready  (n_ready),
    .x_out      (n_x),
    .lz_out     (n_lz),
    .ctl_out    (n_ctl)
  );

  lics_log2 #(
    .LOG_FRAC_BITS (LOG_FRAC_BITS)
  ) u_log2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (n_valid),
    .in_ready  (n_ready),
    .x_in      (n_x),
    .lz_in     (n_lz),
    .ctl_in    (n_ctl),
    .out_valid (l_valid),
    .out_ready (l_ready),
    .t_out     (l_t),
    .ctl_out   (l_ctl)
  );

  lics_scale #(
    .LOG_FRAC_BITS (LOG_FRAC_BITS)
  ) u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (l_valid),
    .in_ready   (l_ready),
    .t_in       (l_t),
    .ctl_in     (l_ctl),
    .inv_scale  (inv_scale_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (out_sample_out),
    .saturated  (out_saturated)
  );

endmodule

`default_nettype wire

>>> tb/laplace_inverse_cdf_sampler_core_tb.sv
`timescale 1ns / 1ps

module laplace_inverse_cdf_sampler_core_tb;
  import lics_pkg::*;

  localparam int FRAC = LOG_FRAC_BITS_DEF;
  localparam int PIPE_LATENCY = FRAC + 11;
  localparam logic [INV_SCALE_W-1:0] SCALE_MAX = {INV_SCALE_W{1'b1}};

  typedef struct {
    logic [31:0] sample_val;
    logic        sat;
  } laplace_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [INV_SCALE_W-1:0] cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [31:0]            in_uniform_in = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic signed [31:0]     out_sample_out;
  logic                   out_saturated;

  laplace_result_t        expected_samples[$];
  logic [INV_SCALE_W-1:0] inv_scale_model = INV_SCALE_RESET;
  bit                     steady_flow = 1'b0;
  int                     samples_sent = 0;
  int                     samples_checked = 0;
  int                     scale_writes = 0;
  int                     mismatch_count = 0;

  laplace_inverse_cdf_sampler_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_uniform_in (in_uniform_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .out_saturated (out_saturated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("laplace_inverse_cdf_sampler_core_tb: errors");
    $finish;
  end

  // Inverse CDF: fold u around one half, take log2 by repeated squaring,
  // convert to ln, scale by 1/lambda and clip to Q16.16.
  function automatic laplace_result_t laplace_sample_of(input logic [31:0] u,
                                                        input logic [INV_SCALE_W-1:0] scale);
    laplace_result_t r;
    logic        neg;
    logic [31:0] m;
    logic [63:0] x, frac, t, ln_q, mag;
    int          e;
    int          i;
    r.sample_val = '0;
    r.sat = 1'b0;
    if (u == 32'd0) begin
      r.sample_val = SAMPLE_MIN;
      r.sat = 1'b1;
      return r;
    end
    neg = (u <= HALF_Q32);
    m = neg ? u : (32'd0 - u);
    e = 0;
    for (i = 0; i < 32; i++) begin
      if (m[i]) e = i;
    end
    x = ({32'd0, m} << (31 - e)) & 64'hFFFF_FFFF;
    frac = '0;
    for (i = 0; i < FRAC; i++) begin
      x = (x * x) >> 31;
      frac = frac << 1;
      if (x >= 64'h1_0000_0000) begin
        frac = frac | 64'd1;
        x = x >> 1;
      end
    end
    t = (64'd31 << FRAC) - ((64'(e) << FRAC) + frac);
    ln_q = (t * {32'd0, LN2_Q32} + {32'd0, HALF_Q32}) >> 32;
    mag = (ln_q * {40'd0, scale} + (64'd1 << (FRAC - 1))) >> FRAC;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        mag = 64'h8000_0000;
        r.sat = 1'b1;
      end
      r.sample_val = 32'd0 - mag[31:0];
    end else begin
      if (mag > 64'h7FFF_FFFF) begin
        mag = 64'h7FFF_FFFF;
        r.sat = 1'b1;
      end
      r.sample_val = mag[31:0];
    end
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_uniform();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom;
    if (r < 52) return $urandom_range(0, 1023);
    if (r < 64) return 32'hFFFF_FFFF - $urandom_range(0, 1023);
    if (r < 76) return HALF_Q32 + $urandom_range(0, 2047) - 32'd1024;
    if (r < 86) return (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 32'd1;
    return $urandom >> $urandom_range(0, 31);
  endfunction

  function automatic logic [INV_SCALE_W-1:0] pick_scale();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return INV_SCALE_W'($urandom_range(1, SCALE_MAX));
    if (r < 80) return INV_SCALE_W'($urandom_range(1, 255));
    return INV_SCALE_W'($urandom_range(SCALE_MAX - 255, SCALE_MAX));
  endfunction

  // Result side: check each transfer, then roll the next ready level.
  initial begin
    int             stall_left;
    laplace_result_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected result: sample_out %h saturated %b", out_sample_out, out_saturated);
          mismatch_count++;
        end else begin
          want = expected_samples.pop_front();
          samples_checked++;
          if (out_sample_out !== want.sample_val) begin
            $error("sample_out mismatch: expected %h, actual %h", want.sample_val, out_sample_out);
            mismatch_count++;
          end
          if (out_saturated !== want.sat) begin
            $error("saturated mismatch: expected %b, actual %b", want.sat, out_saturated);
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!steady_flow && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Hold valid high across back-to-back transfers; drop it only for a gap.
  task automatic send_uniform(input logic [31:0] u);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_uniform_in <= u;
    do @(posedge clk); while (!in_ready);
    expected_samples.push_back(laplace_sample_of(u, inv_scale_model));
    samples_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  task automatic write_scale(input logic [INV_SCALE_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    inv_scale_model = value;
    scale_writes++;
  endtask

  task automatic test_reset_scale();
    logic [31:0] pts[11];
    pts = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0001_0000, 32'h4000_0000,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'hC000_0000, 32'hFFFF_FFFE,
            32'hFFFF_FFFF};
    foreach (pts[i]) send_uniform(pts[i]);
  endtask

  task automatic test_scale_extremes();
    logic [31:0] pts[6];
    pts = '{32'h0000_0000, 32'h0000_0001, 32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF,
            32'h5555_5555};
    write_scale(SCALE_MAX);
    foreach (pts[i]) send_uniform(pts[i]);
    write_scale(24'd1);
    foreach (pts[i]) send_uniform(pts[i]);
  endtask

  task automatic test_random_traffic();
    int                     p;
    int                     n;
    logic [INV_SCALE_W-1:0] scale;
    for (p = 0; p < 7; p++) begin
      case (p)
        0: scale = SCALE_MAX;
        1: scale = 24'd1;
        2: scale = INV_SCALE_RESET;
        default: scale = pick_scale();
      endcase
      write_scale(scale);
      steady_flow = (p == 3);
      for (n = 0; n < 250; n++) send_uniform(pick_uniform());
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_scale();
    test_scale_extremes();
    test_random_traffic();
    wait_drained();
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (expected_samples.size() != 0) begin
      $error("%0d expected samples never arrived", expected_samples.size());
      mismatch_count++;
    end
    $display("run covered %0d uniform inputs over %0d scale writes (1 to 0x%h, reset 1.0),",
             samples_sent, scale_writes, SCALE_MAX);
    $display("%0d samples checked, %0d mismatches", samples_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("laplace_inverse_cdf_sampler_core_tb: clean");
    end else begin
      $display("laplace_inverse_cdf_sampler_core_tb: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/lics_pkg.sv
rtl/lics_norm.sv
rtl/lics_log2.sv
rtl/lics_scale.sv
rtl/laplace_inverse_cdf_sampler_core.sv
tb/laplace_inverse_cdf_sampler_core_tb.sv
